### rtl/fbfl_pkg.sv
// Package for the fixed-block free-list allocator.
// Holds the fixed field widths, operation and status codes, the used-count limit, and the result and status word types.
// No dependencies.
`default_nettype none

package fbfl_pkg;

  localparam int OpW     = 2;
  localparam int IndexW  = 10;
  localparam int CountW  = 11;
  localparam int StatusW = 2;

  localparam logic [OpW-1:0] OpAlloc = 2'd0;
  localparam logic [OpW-1:0] OpFree  = 2'd1;
  localparam logic [OpW-1:0] OpInit  = 2'd2;

  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StEmpty   = 2'd1;
  localparam logic [StatusW-1:0] StBadFree = 2'd2;

  localparam logic [CountW-1:0] UsedMax = 11'd2047;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IndexW-1:0]  granted_index;
    logic [CountW-1:0]  used_count;
  } fbfl_res_t;

  typedef struct packed {
    logic busy;      // sequencer is not in its idle state
    logic alloc_rd;  // waiting on the link read of a pop
  } fbfl_stat_t;

endpackage

`default_nettype wire

### rtl/fbfl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module fbfl_ram #(
  parameter int Width = 11,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/fbfl_ctrl.sv
// Sequencer of the free-list allocator: head and used-count registers, pop/push,
// init walk over the link RAM. Depends on fbfl_pkg.
`default_nettype none

module fbfl_ctrl
  import fbfl_pkg::*;
#(
  parameter int MaxBlocks = 1024,
  parameter int AddrW     = $clog2(MaxBlocks),
  parameter int LinkW     = $clog2(MaxBlocks + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CountW-1:0] cfg_pool_blocks_i,
  input  wire logic              in_valid_i,
  input  wire logic [OpW-1:0]    operation_i,
  input  wire logic [IndexW-1:0] block_index_i,
  input  wire logic              space_i,
  output      logic              in_ready_o,
  output      logic              res_valid_o,
  output      fbfl_res_t         res_o,
  output      logic              ram_we_o,
  output      logic [AddrW-1:0]  ram_waddr_o,
  output      logic [LinkW-1:0]  ram_wdata_o,
  output      logic              ram_re_o,
  output      logic [AddrW-1:0]  ram_raddr_o,
  input  wire logic [LinkW-1:0]  ram_rdata_i,
  output      fbfl_stat_t        stat_o
);

  localparam int CmpW = (LinkW > CountW) ? LinkW : CountW;
  localparam logic [LinkW-1:0] LinkNull = LinkW'(MaxBlocks);

  localparam logic [1:0] StIdle    = 2'd0;
  localparam logic [1:0] StAllocRd = 2'd1;
  localparam logic [1:0] StInit    = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [LinkW-1:0]  head_q, head_d;
  logic [CountW-1:0] used_q, used_d;
  logic [LinkW-1:0]  cnt_q, cnt_d;
  logic [CountW-1:0] pool_blocks_q;

  logic [CmpW-1:0]   bc_ext;
  logic [CmpW-1:0]   pool_ext;
  logic [LinkW-1:0]  pool;
  logic [LinkW-1:0]  cnt_inc;
  logic              accept;
  logic              bad_free;

  // Saturate the pool size at the link store depth.
  assign bc_ext   = CmpW'(pool_blocks_q);
  assign pool_ext = (bc_ext > CmpW'(MaxBlocks)) ? CmpW'(MaxBlocks) : bc_ext;
  assign pool     = LinkW'(pool_ext);
  assign cnt_inc  = LinkW'(cnt_q + 1'b1);

  assign in_ready_o  = (state_q == StIdle) && space_i;
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = accept;
  assign bad_free    = (CmpW'(block_index_i) >= pool_ext) || (used_q == '0);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    used_d      = used_q;
    cnt_d       = cnt_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = AddrW'(block_index_i);
    ram_wdata_o = head_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = AddrW'(head_q);
    res_o.status        = StOk;
    res_o.granted_index = '0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          case (operation_i)
            OpAlloc: begin
              if (head_q >= LinkNull) begin
                res_o.status = StEmpty;
              end else begin
                res_o.granted_index = IndexW'(head_q);
                ram_re_o = 1'b1;
                used_d   = (used_q == UsedMax) ? used_q : CountW'(used_q + 1'b1);
                state_d  = StAllocRd;
              end
            end
            OpFree: begin
              if (bad_free) begin
                res_o.status = StBadFree;
              end else begin
                ram_we_o = 1'b1;
                head_d   = LinkW'(block_index_i);
                used_d   = CountW'(used_q - 1'b1);
              end
            end
            OpInit: begin
              used_d = '0;
              cnt_d  = '0;
              if (pool != '0) begin
                head_d  = '0;
                state_d = StInit;
              end else begin
                head_d = LinkNull;
              end
            end
            default: ;
          endcase
        end
      end
      StAllocRd: begin
        // Take the popped entry's link as the new head.
        head_d  = ram_rdata_i;
        state_d = StIdle;
      end
      StInit: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = AddrW'(cnt_q);
        if (cnt_inc == pool) begin
          ram_wdata_o = LinkNull;
          state_d     = StIdle;
        end else begin
          ram_wdata_o = cnt_inc;
          cnt_d       = cnt_inc;
        end
      end
      default: state_d = StIdle;
    endcase

    res_o.used_count = used_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      head_q        <= LinkNull;
      used_q        <= '0;
      cnt_q         <= '0;
      pool_blocks_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      used_q  <= used_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        pool_blocks_q <= cfg_pool_blocks_i;
      end
    end
  end

  assign stat_o.busy     = (state_q != StIdle);
  assign stat_o.alloc_rd = (state_q == StAllocRd);

endmodule

`default_nettype wire

### rtl/fbfl_outq.sv
// Two-entry result buffer: an output register and one holding register behind it.
// Depends on fbfl_pkg.
`default_nettype none

module fbfl_outq
  import fbfl_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire fbfl_res_t push_data_i,
  output      logic      space_o,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      fbfl_res_t out_data_o
);

  logic      out_valid_q, out_valid_d;
  logic      hold_valid_q, hold_valid_d;
  fbfl_res_t out_q, out_d;
  fbfl_res_t hold_q, hold_d;
  logic      pop;

  assign pop     = out_valid_q && out_ready_i;
  assign space_o = !hold_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    hold_valid_d = hold_valid_q;
    out_d        = out_q;
    hold_d       = hold_q;
    if (pop && hold_valid_q) begin
      out_d        = hold_q;
      hold_valid_d = 1'b0;
    end else if (push_i && (!out_valid_q || pop)) begin
      out_d       = push_data_i;
      out_valid_d = 1'b1;
    end else if (push_i) begin
      hold_d       = push_data_i;
      hold_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/fixed_block_free_list_allocator_unit.sv
// Top level of the fixed-block free-list allocator.
// Depends on fbfl_pkg, fbfl_ram, fbfl_ctrl and fbfl_outq.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one word per item: operation_i
//    (allocate, free, initialize) and block_index_i (used by free only).
//  - Output channel (out_valid_o/out_ready_i) returns one word per item: status_o,
//    granted_index_o and used_count_o, in item order.
//  - cfg_we_i writes cfg_pool_blocks_i into the pool size register; write it only
//    while the block is idle. Sizes above MaxBlocks saturate.
//  - The result is written into the result buffer when the item is accepted.
//  - Free and rejected items leave the sequencer idle; a successful allocate first
//    reads the popped entry's link from the RAM, and initialize makes one RAM write
//    per block linked (min(pool size, MaxBlocks) blocks), before the next item is
//    accepted.
//  - Reset empties the free list, clears the used count and the size register.
//    The link RAM is not cleared; initialize fills it.
//  - A stalled receiver: one finished result waits in the output register while
//    one more item is accepted into a holding register; then in_ready_o drops.
`default_nettype none

module fixed_block_free_list_allocator_unit
  import fbfl_pkg::*;
#(
  parameter int MaxBlocks = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CountW-1:0]  cfg_pool_blocks_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [OpW-1:0]     operation_i,
  input  wire logic [IndexW-1:0]  block_index_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [StatusW-1:0] status_o,
  output      logic [IndexW-1:0]  granted_index_o,
  output      logic [CountW-1:0]  used_count_o
);

  localparam int AddrW = $clog2(MaxBlocks);
  localparam int LinkW = $clog2(MaxBlocks + 1);

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [LinkW-1:0] ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [LinkW-1:0] ram_rdata;

  logic       space;
  logic       res_valid;
  fbfl_res_t  res;
  fbfl_res_t  out_data;
  fbfl_stat_t stat;
  logic       in_accept;

  assign in_accept = in_valid_i && in_ready_o;

  // Sequencer: owns head, used count and the init walk.
  fbfl_ctrl #(
    .MaxBlocks(MaxBlocks),
    .AddrW    (AddrW),
    .LinkW    (LinkW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_pool_blocks_i(cfg_pool_blocks_i),
    .in_valid_i       (in_valid_i),
    .operation_i      (operation_i),
    .block_index_i    (block_index_i),
    .space_i          (space),
    .in_ready_o       (in_ready_o),
    .res_valid_o      (res_valid),
    .res_o            (res),
    .ram_we_o         (ram_we),
    .ram_waddr_o      (ram_waddr),
    .ram_wdata_o      (ram_wdata),
    .ram_re_o         (ram_re),
    .ram_raddr_o      (ram_raddr),
    .ram_rdata_i      (ram_rdata),
    .stat_o           (stat)
  );

  // Next-link store, one entry per block.
  fbfl_ram #(
    .Width(LinkW),
    .Depth(MaxBlocks)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Result buffer decouples the receiver from the sequencer.
  fbfl_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data)
  );

  assign status_o        = out_data.status;
  assign granted_index_o = out_data.granted_index;
  assign used_count_o    = out_data.used_count;

  // The output is valid in the cycle after every accepted word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("accepted word produced no result");

  // No new word while the sequencer is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |-> !in_ready_o)
    else $error("input ready while sequencer busy");

  // The link read state follows an accepted allocate only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.alloc_rd |-> ($past(in_accept) && $past(operation_i) == OpAlloc))
    else $error("link read state without an allocate");

  // Failed items never grant a block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StOk) |-> (granted_index_o == '0))
    else $error("nonzero grant on failed item");

endmodule

`default_nettype wire
